// ----- src/fnec_pkg.sv -----
// shared types, codes and constants for the float near-equal compare block
// no dependencies

package fnec_pkg;

  localparam logic [1:0] MODE_NEAR = 2'd0;
  localparam logic [1:0] MODE_GE   = 2'd1;
  localparam logic [1:0] MODE_LE   = 2'd2;

  localparam logic [31:0] EPS_RESET    = 32'h3400_0000;
  localparam logic [30:0] INF_MAG      = 31'h7F80_0000;
  localparam logic [30:0] FLT_MAX_MAG  = 31'h7F7F_FFFF;
  localparam int          QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        eq;
    logic        gt;
    logic        lt;
    logic        use_abs;
    logic        opp;
    logic [1:0]  mode;
    logic [7:0]  ex;
    logic [23:0] sx;
    logic [7:0]  ey;
    logic [23:0] sy;
  } fnec_item_t;

endpackage

// ----- src/fnec_front.sv -----
// front end: takes operand transactions, classifies them and orders the magnitudes
// depends on fnec_pkg

module fnec_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [31:0]          in_a,
  input  logic [31:0]          in_b,
  output logic                 item_valid,
  input  logic                 item_ready,
  output fnec_pkg::fnec_item_t item
);
  import fnec_pkg::*;

  logic       valid_r;
  fnec_item_t item_r;
  fnec_item_t item_nxt;

  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_ge;
  logic [23:0] frac_sum;

  always_comb begin
    ea = in_a[30:23];
    eb = in_b[30:23];
    fa = in_a[22:0];
    fb = in_b[22:0];
    nan_a  = (ea == 8'hFF) && (fa != 23'd0);
    nan_b  = (eb == 8'hFF) && (fb != 23'd0);
    inf_a  = (ea == 8'hFF) && (fa == 23'd0);
    inf_b  = (eb == 8'hFF) && (fb == 23'd0);
    zero_a = (in_a[30:0] == 31'd0);
    zero_b = (in_b[30:0] == 31'd0);
    a_ge   = (in_a[30:0] >= in_b[30:0]);
    frac_sum = {1'b0, fa} + {1'b0, fb};

    item_nxt.nan  = nan_a || nan_b;
    item_nxt.inf  = inf_a || inf_b;
    item_nxt.eq   = !item_nxt.nan && ((in_a == in_b) || (zero_a && zero_b));
    if (in_a[31] != in_b[31]) begin
      item_nxt.gt = !in_a[31];
    end else if (in_a[31]) begin
      item_nxt.gt = (in_a[30:0] < in_b[30:0]);
    end else begin
      item_nxt.gt = (in_a[30:0] > in_b[30:0]);
    end
    item_nxt.gt = item_nxt.gt && !item_nxt.nan && !item_nxt.eq;
    item_nxt.lt = !item_nxt.gt && !item_nxt.nan && !item_nxt.eq;
    item_nxt.use_abs = zero_a || zero_b ||
                       ((ea == 8'd0) && (eb == 8'd0) && !frac_sum[23]);
    item_nxt.opp  = in_a[31] ^ in_b[31];
    item_nxt.mode = in_mode;
    if (a_ge) begin
      item_nxt.ex = (ea == 8'd0) ? 8'd1 : ea;
      item_nxt.sx = {ea != 8'd0, fa};
      item_nxt.ey = (eb == 8'd0) ? 8'd1 : eb;
      item_nxt.sy = {eb != 8'd0, fb};
    end else begin
      item_nxt.ex = (eb == 8'd0) ? 8'd1 : eb;
      item_nxt.sx = {eb != 8'd0, fb};
      item_nxt.ey = (ea == 8'd0) ? 8'd1 : ea;
      item_nxt.sy = {ea != 8'd0, fa};
    end
  end

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- src/fnec_queue.sv -----
// short queue between front and back ends
// depends on fnec_pkg

module fnec_queue #(
  parameter int DEPTH = fnec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  fnec_pkg::fnec_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output fnec_pkg::fnec_item_t pop_item
);
  import fnec_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  fnec_item_t      mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/fnec_back.sv -----
// back end: tolerance register, magnitude add and subtract, rounding and the tolerance test
// depends on fnec_pkg

module fnec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  fnec_pkg::fnec_item_t item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_verdict
);
  import fnec_pkg::*;

  typedef struct packed {
    logic [8:0]  field;
    logic [26:0] n;
  } norm_t;

  function automatic norm_t norm(input logic [27:0] m, input logic [7:0] ex);
    norm_t      r;
    logic [4:0] p;
    logic [4:0] sh_n;
    logic [7:0] sh_s;
    logic [4:0] sh;
    logic [8:0] e_n;
    p = '0;
    for (int i = 0; i < 27; i++) begin
      if (m[i]) p = 5'(i);
    end
    if (m[27]) begin
      r.n     = {m[27:2], m[1] | m[0]};
      r.field = {1'b0, ex} + 9'd1;
    end else begin
      sh_n    = 5'd26 - p;
      sh_s    = ex - 8'd1;
      sh      = ({3'b0, sh_n} <= sh_s) ? sh_n : sh_s[4:0];
      r.n     = m[26:0] << sh;
      e_n     = {1'b0, ex} + {4'b0, p} - 9'd26;
      r.field = r.n[26] ? e_n : 9'd0;
    end
    return r;
  endfunction

  function automatic logic [30:0] rnd(input norm_t x);
    logic        up;
    logic [30:0] pat;
    up = x.n[2] & (x.n[3] | x.n[1] | x.n[0]);
    if (x.field >= 9'd255) begin
      pat = INF_MAG;
    end else begin
      pat = {x.field[7:0], x.n[25:3]} + 31'(up);
    end
    return pat;
  endfunction

  // tolerance register and the constants derived from it
  logic [31:0] eps_r;
  logic        d_rel_all_r, d_rel_none_r, d_le_r;
  logic [25:0] d_mm_r;
  logic [7:0]  d_ee_r;
  logic [30:0] d_tol_r;

  logic [7:0]  eps_e, eps_ee;
  logic [23:0] eps_sig;
  logic        eps_pos;
  logic [7:0]  tol_r8;
  logic [48:0] tol_w;
  logic [23:0] tol_n;
  logic        tol_up;
  logic [30:0] tol_nxt;
  logic [25:0] mm_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    eps_e   = eps_r[30:23];
    eps_ee  = (eps_e == 8'd0) ? 8'd1 : eps_e;
    eps_sig = {eps_e != 8'd0, eps_r[22:0]};
    eps_pos = !eps_r[31] && (eps_r[30:0] != 31'd0) &&
              !((eps_e == 8'hFF) && (eps_r[22:0] != 23'd0));
    if ((eps_r[22:0] == 23'd0) && (eps_e >= 8'd2)) begin
      mm_nxt = {eps_sig, 2'b00} - 26'd1;
    end else begin
      mm_nxt = {eps_sig, 2'b00} - 26'd2;
    end
    tol_r8 = 8'd127 - eps_ee;
    tol_w  = {eps_sig, 25'b0} >> tol_r8[4:0];
    tol_n  = tol_w[48:25];
    tol_up = tol_w[24] & (tol_n[0] | (|tol_w[23:0]));
    if (!eps_pos) begin
      tol_nxt = '0;
    end else if (eps_e == 8'hFF) begin
      tol_nxt = INF_MAG;
    end else if (eps_e > 8'd126) begin
      tol_nxt = {eps_e - 8'd126, eps_r[22:0]};
    end else if (tol_r8 > 8'd25) begin
      tol_nxt = '0;
    end else begin
      tol_nxt = {7'b0, tol_n} + 31'(tol_up);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    d_rel_all_r  <= eps_pos && (eps_e >= 8'd128);
    d_rel_none_r <= !eps_pos;
    d_le_r       <= eps_r[0];
    d_mm_r       <= mm_nxt;
    d_ee_r       <= eps_ee;
    d_tol_r      <= tol_nxt;
  end

  // pipeline
  logic en;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r, out_verdict_r;
  fnec_item_t s1_c_r, s2_c_r, s3_c_r, s4_c_r;

  logic [27:0] s1_sum_r;
  logic [26:0] s1_dif_r;
  norm_t       s2_sum_r, s2_dif_r;
  logic [30:0] s3_sum_r, s3_diff_r;
  logic [49:0] s4_prod_r;
  logic [23:0] s4_sd_r;
  logic signed [10:0] s4_t_r;
  logic        s4_abs_r, s4_dinf_r;

  assign en         = !out_valid_r || out_ready;
  assign item_ready = en;
  assign out_valid  = out_valid_r;
  assign out_verdict = out_verdict_r;

  // stage 1: alignment and add/subtract of magnitudes
  logic [7:0]  al_d;
  logic [4:0]  al_sh;
  logic [53:0] al_w;
  logic [26:0] al_x, al_y;

  always_comb begin
    al_d  = item.ex - item.ey;
    al_sh = (al_d > 8'd27) ? 5'd27 : al_d[4:0];
    al_w  = {item.sy, 3'b000, 27'b0} >> al_sh;
    al_x  = {item.sx, 3'b000};
    al_y  = {al_w[53:28], al_w[27] | (|al_w[26:0])};
  end

  // stage 4 inputs
  logic [30:0] lim;
  logic [23:0] sl, sd;
  logic [7:0]  ed;
  logic signed [10:0] t_nxt;

  always_comb begin
    lim   = (s3_sum_r >= INF_MAG) ? FLT_MAX_MAG : s3_sum_r;
    sl    = {lim[30:23] != 8'd0, lim[22:0]};
    sd    = {s3_diff_r[30:23] != 8'd0, s3_diff_r[22:0]};
    ed    = (s3_diff_r[30:23] == 8'd0) ? 8'd1 : s3_diff_r[30:23];
    t_nxt = $signed({3'b0, ed}) - $signed({3'b0, d_ee_r}) + 11'sd152
            - $signed({3'b0, lim[30:23]});
  end

  // stage 5: relative test and verdict
  logic [74:0] a_sh, r_ext;
  logic        cmp, rel_ok, near, verdict_nxt;

  always_comb begin
    a_sh  = {51'b0, s4_sd_r} << s4_t_r[5:0];
    r_ext = {25'b0, s4_prod_r};
    if (s4_t_r <= 11'sd0) begin
      cmp = 1'b1;
    end else if (s4_t_r >= 11'sd51) begin
      cmp = 1'b0;
    end else begin
      cmp = (a_sh < r_ext) || (d_le_r && (a_sh == r_ext));
    end
    rel_ok = !s4_dinf_r && (d_rel_all_r || (!d_rel_none_r && cmp));
    near   = s4_c_r.eq || (!s4_c_r.nan && !s4_c_r.inf &&
                           (s4_c_r.use_abs ? s4_abs_r : rel_ok));
    verdict_nxt = near || ((s4_c_r.mode == MODE_GE) && s4_c_r.gt) ||
                  ((s4_c_r.mode == MODE_LE) && s4_c_r.lt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= item_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c_r    <= item;
      s1_sum_r  <= {1'b0, al_x} + {1'b0, al_y};
      s1_dif_r  <= al_x - al_y;
      s2_c_r    <= s1_c_r;
      s2_sum_r  <= norm(s1_sum_r, s1_c_r.ex);
      s2_dif_r  <= norm({1'b0, s1_dif_r}, s1_c_r.ex);
      s3_c_r    <= s2_c_r;
      s3_sum_r  <= rnd(s2_sum_r);
      s3_diff_r <= s2_c_r.opp ? rnd(s2_sum_r) : rnd(s2_dif_r);
      s4_c_r    <= s3_c_r;
      s4_prod_r <= d_mm_r * sl;
      s4_sd_r   <= sd;
      s4_t_r    <= t_nxt;
      s4_abs_r  <= (s3_diff_r < d_tol_r);
      s4_dinf_r <= (s3_diff_r >= INF_MAG);
      out_verdict_r <= verdict_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_v_r && s4_c_r.nan) |=> !out_verdict_r)
    else $error("nan operand gave a true verdict");

  assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_v_r && s4_c_r.eq) |=> out_verdict_r)
    else $error("equal operands gave a false verdict");

  assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_v_r && s4_c_r.gt && (s4_c_r.mode == MODE_GE)) |=> out_verdict_r)
    else $error("greater operand failed greater-or-near mode");

endmodule

// ----- src/float_near_equal_compare.sv -----
// top level of the float near-equal compare block
// depends on fnec_pkg, fnec_front, fnec_queue and fnec_back

// Compares two single-precision operands for near-equality (or greater/less-or-near
// per mode) against a tolerance held in one register (reset 2^-23), relative except
// near zero, and returns one flag per operand transaction. One transaction is
// accepted every clock cycle while the queue has room; the classify register
// loads at the accepting edge, followed by the queue, the four back-end stages
// (align, normalise, round, multiply) and the output register. The queue lets the
// input side keep accepting while a result waits.

module float_near_equal_compare #(
  parameter int QUEUE_DEPTH = fnec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // b_bits [63:32], a_bits [31:0]
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // zero fill, verdict in bit 0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import fnec_pkg::*;

  fnec_item_t f_item, q_item;
  logic       f_valid, f_ready, q_valid, q_ready, verdict;

  fnec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_a       (in_tdata[31:0]),
    .in_b       (in_tdata[63:32]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  fnec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  fnec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .item        (q_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_verdict (verdict)
  );

  assign out_tdata = {7'b0, verdict};

endmodule
